FILE: sv/smap_pkg.sv
// Shared constants and interface structs of the suffix match action predictor.
package smap_pkg;

    localparam int NUM_STREAMS_DEF = 2;
    localparam int HISTORY_LEN_DEF = 16;
    localparam int MAX_MATCH_DEF   = 4;
    localparam int ACT_W           = 8;

    typedef struct packed {
        logic clr;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic             found;
        logic [ACT_W-1:0] pred;
    } t_scan_res;

endpackage

FILE: sv/smap_hist_ram.sv
// History byte RAM: one write port, one read port with registered read data.
module smap_hist_ram import smap_pkg::*; #(
    parameter int AW = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [ACT_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [ACT_W-1:0] o_rdata
);

    logic [ACT_W-1:0] r_mem [2**AW];
    logic [ACT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/smap_scan.sv
// Suffix window scanner: consumes history bytes newest first, tracks first match per length.
module smap_scan import smap_pkg::*; #(
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int MAX_MATCH   = MAX_MATCH_DEF,
    localparam int QW         = $clog2(HISTORY_LEN)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [QW-1:0]    i_q,
    input  logic [ACT_W-1:0] i_byte,
    output t_scan_res        o_res
);

    logic [ACT_W-1:0] r_win [MAX_MATCH];
    logic [ACT_W-1:0] r_sfx [MAX_MATCH];
    logic [ACT_W-1:0] r_nxt [MAX_MATCH];
    logic [MAX_MATCH-1:0] r_found;
    logic [ACT_W-1:0] cand [MAX_MATCH+1];
    logic [MAX_MATCH-1:0] match;

    // cand[k] is the history byte at position q+k
    always_comb begin
        cand[0] = i_byte;
        for (int k = 1; k <= MAX_MATCH; k++) begin
            cand[k] = r_win[k-1];
        end
    end

    for (genvar l = 1; l <= MAX_MATCH; l++) begin : g_len
        logic m;
        always_comb begin
            m = (int'(i_q) <= HISTORY_LEN - l - 1);
            for (int k = 0; k < l; k++) begin
                if (cand[k] != r_sfx[MAX_MATCH-l+k]) begin
                    m = 1'b0;
                end
            end
        end
        assign match[l-1] = m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= '0;
        end else if (i_ctl.clr) begin
            r_found <= '0;
        end else if (i_ctl.step) begin
            r_found <= r_found | match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            for (int k = 0; k < MAX_MATCH; k++) begin
                r_win[k] <= cand[k];
                if (i_q == QW'(HISTORY_LEN - MAX_MATCH + k)) begin
                    r_sfx[k] <= i_byte;
                end
                if (match[k] && !r_found[k]) begin
                    r_nxt[k] <= cand[k+1];
                end
            end
        end
    end

    // longest length wins
    always_comb begin
        o_res.found = |r_found;
        o_res.pred  = '0;
        for (int l = 0; l < MAX_MATCH; l++) begin
            if (r_found[l]) begin
                o_res.pred = r_nxt[l];
            end
        end
    end

endmodule

FILE: sv/suffix_match_action_predictor.sv
// Top level of the suffix match action predictor: control, stream pointers, output register.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------------------------
//   in       | i_in_valid / o_in_stall  | i_stream_index, i_action
//   out      | o_out_valid / i_out_stall| o_predicted_action, o_match_found, o_prediction_hit
//
// A word for a valid stream passes S_IDLE, which accepts it and writes the new byte, then
// S_SCAN, which reads the history through the single RAM read port (one history byte a cycle),
// then S_DONE, which loads the result. A word for a stream out of range skips S_SCAN.
// After reset a clearing pass writes zero to all 2**(SIW+SW) RAM entries (32 by default)
// while o_in_stall is high. The result register holds a valid word while i_out_stall is high; the next
// word is accepted and scanned meanwhile and waits before its result load.
module suffix_match_action_predictor import smap_pkg::*; #(
    parameter int NUM_STREAMS = NUM_STREAMS_DEF,
    parameter int HISTORY_LEN = HISTORY_LEN_DEF,
    parameter int MAX_MATCH   = MAX_MATCH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_stream_index,
    input  logic [ACT_W-1:0] i_action,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ACT_W-1:0] o_predicted_action,
    output logic             o_match_found,
    output logic             o_prediction_hit
);

    localparam int SW  = $clog2(HISTORY_LEN);
    localparam int SIW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int AW  = SIW + SW;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr;
    logic [SIW-1:0]   r_stream;
    logic [ACT_W-1:0] r_action;
    logic             r_hit;
    logic [SW-1:0]    r_q;
    logic [SW-1:0]    r_rd_slot;
    logic [SW-1:0]    r_head [NUM_STREAMS];
    logic [ACT_W-1:0] r_pred [NUM_STREAMS];
    logic             r_out_valid;
    logic [ACT_W-1:0] r_out_pred;
    logic             r_out_match;
    logic             r_out_hit;

    logic             in_acc;
    logic             in_oor;
    logic [SIW-1:0]   s_ext;
    logic [SIW-1:0]   s_sel;
    logic [SW-1:0]    head_sel;
    logic             out_free;
    logic             res_load;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ACT_W-1:0] ram_wdata;
    logic [ACT_W-1:0] ram_rdata;
    logic [ACT_W-1:0] scan_byte;
    t_scan_ctl        scan_ctl;
    t_scan_res        scan_res;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(HISTORY_LEN - 1)) ? '0 : s + SW'(1);
    endfunction

    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
        return (s == '0) ? SW'(HISTORY_LEN - 1) : s - SW'(1);
    endfunction

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign s_ext    = SIW'(i_stream_index);
    assign in_oor   = int'(s_ext) >= NUM_STREAMS;
    assign s_sel    = in_oor ? '0 : s_ext;
    assign head_sel = r_head[s_sel];
    assign out_free = !r_out_valid || !i_out_stall;
    assign res_load = (r_state == S_DONE) && out_free;

    // RAM holds each stream as a ring; the slot at the head pointer is the oldest byte
    assign ram_we    = (r_state == S_CLEAR) || (in_acc && !in_oor);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : {s_sel, head_sel};
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : i_action;

    smap_hist_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr ({r_stream, r_rd_slot}),
        .o_rdata (ram_rdata)
    );

    assign scan_ctl.clr  = in_acc;
    assign scan_ctl.step = (r_state == S_SCAN);
    assign scan_byte     = (r_q == SW'(HISTORY_LEN - 1)) ? r_action : ram_rdata;

    smap_scan #(
        .HISTORY_LEN (HISTORY_LEN),
        .MAX_MATCH   (MAX_MATCH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_q     (r_q),
        .i_byte  (scan_byte),
        .o_res   (scan_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = in_oor ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_q == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_STREAMS; i++) begin
                r_head[i] <= '0;
                r_pred[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (in_acc && !in_oor) begin
                r_head[s_sel] <= slot_inc(head_sel);
            end
            if (res_load && scan_res.found) begin
                r_pred[r_stream] <= scan_res.pred;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stream  <= s_sel;
            r_action  <= i_action;
            r_hit     <= !in_oor && (r_pred[s_sel] == i_action);
            r_q       <= SW'(HISTORY_LEN - 1);
            r_rd_slot <= slot_dec(head_sel);
        end else if (r_state == S_SCAN) begin
            r_q       <= r_q - SW'(1);
            r_rd_slot <= slot_dec(r_rd_slot);
        end
        if (res_load) begin
            r_out_pred  <= scan_res.pred;
            r_out_match <= scan_res.found;
            r_out_hit   <= r_hit;
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_predicted_action = r_out_pred;
    assign o_match_found      = r_out_match;
    assign o_prediction_hit   = r_out_hit;

endmodule

FILE: sv/smap_checker.sv
// Port-level assertions for the suffix match action predictor, bound to the top level.
module smap_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_stream_index,
    input logic [7:0] i_action,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_predicted_action,
    input logic       o_match_found,
    input logic       o_prediction_hit
);

    // reset empties the result register and starts the clearing pass
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("result pending or input open after reset");

    // one word in flight: a word is never accepted right after another
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    // no match gives a zero prediction
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_match_found) |-> (o_predicted_action == 8'd0))
        else $error("nonzero prediction without match");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_predicted_action)
            && $stable(o_match_found) && $stable(o_prediction_hit))
        else $error("stalled result word changed");

endmodule

bind suffix_match_action_predictor smap_checker u_smap_checker (.*);
